>>> hw/rtl/stpe_pkg.sv
// Package for the sync triggered packet extractor: sizes, codes, shared types.
// No dependencies; imported by stpe_front, stpe_back and the top level.
package stpe_pkg;

   localparam int MAX_LEN       = 32;
   localparam int MAX_PENDING   = 2;
   localparam int MAX_RESULTS   = 64;
   localparam int BITS_PER_BYTE = 8;

   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int RING_AW    = $clog2(2 * MAX_LEN);
   localparam int RING_DEPTH = 1 << RING_AW;
   localparam int EMIT_N     = MAX_PENDING + 1;
   localparam int ECNT_W     = $clog2(EMIT_N + 1);
   localparam int PK_W       = $clog2(EMIT_N);
   localparam int SLOT_W     = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
   localparam int SLOT_CW    = $clog2(MAX_PENDING + 1);
   localparam int RES_W      = $clog2(MAX_RESULTS + 1);
   localparam int BIT_W      = $clog2(BITS_PER_BYTE);

   localparam int CMD_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PKT_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PACK_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_LENGTH = 2'd2;

   localparam logic [5:0] PKT_LEN_RST = 6'd32;

   typedef struct packed {
      logic [5:0] pkt_len;
      logic       pack_bits;
      logic       use_length;
   } cfg_type;

   typedef struct packed {
      logic [ECNT_W-1:0]            count;
      logic                         ovf;
      logic [RING_AW-1:0]           end_pos;
      logic [EMIT_N-1:0][LEN_W-1:0] lens;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_value;
      logic       last;
      logic       empty_res;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
      logic [7:0]         data;
   } ring_wr_type;

   typedef struct packed {
      logic               valid;
      logic [RING_AW-1:0] end_pos;
   } back_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SETUP,
      BK_RUN
   } back_state_type;

endpackage

>>> hw/rtl/stpe_fifo.sv
// Small register queue, first word in first out, head visible while not empty.
// No dependencies; used for the command queue and the result queue.
module stpe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                       full,
   output logic                       empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> hw/rtl/stpe_front.sv
// Front end: takes input words, writes the history ring, keeps the pending table
// and issues one command per word that completes packets. Uses stpe_pkg.
module stpe_front
   import stpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_push,
   output logic          req_full,
   input  logic [7:0]    req_sample,
   input  logic          req_sync,
   input  logic          req_length_valid,
   input  logic [15:0]   req_length,
   input  logic          cmd_full,
   input  back_stat_type bstat,
   output logic          cmd_push,
   output cmd_type       cmd_wdata,
   output ring_wr_type   ring_wr
);

   logic [RING_AW-1:0] wp_ff, wp_in;
   logic               ovf_ff, ovf_in;
   logic [MAX_PENDING-1:0]            pv_ff, pv_in;
   logic [MAX_PENDING-1:0][LEN_W-1:0] prem_ff, prem_in;
   logic [MAX_PENDING-1:0][LEN_W-1:0] plen_ff, plen_in;

   logic                         accept, ring_safe;
   logic [RING_AW-1:0]           gap;
   logic [LEN_W-1:0]             eff, newlen;
   logic                         is_short, drop;
   logic [SLOT_CW-1:0]           used, n;
   logic [ECNT_W-1:0]            ne;
   logic [EMIT_N-1:0][LEN_W-1:0] elens;

   assign gap       = wp_ff - bstat.end_pos;
   assign ring_safe = !bstat.valid ||
                      ((gap != '0) && (gap <= RING_AW'(RING_DEPTH - MAX_LEN)));
   assign req_full  = cmd_full || !ring_safe;
   assign accept    = req_push && !req_full;

   assign ring_wr.en   = accept;
   assign ring_wr.addr = wp_ff;
   assign ring_wr.data = req_sample;

   always_comb begin
      eff      = (32'(cfg.pkt_len) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(cfg.pkt_len);
      newlen   = eff;
      if (cfg.use_length && req_length_valid && (32'(req_length) < 32'(eff))) begin
         newlen = LEN_W'(req_length);
      end
      is_short = (newlen <= LEN_W'(1));

      used = '0;
      for (int i = 0; i < MAX_PENDING; i++) begin
         if (pv_ff[i] && (prem_ff[i] > LEN_W'(1))) begin
            used = used + SLOT_CW'(1);
         end
      end
      drop = req_sync && !is_short && (32'(used) >= MAX_PENDING);

      pv_in   = '0;
      prem_in = '0;
      plen_in = '0;
      elens   = '0;
      n       = '0;
      ne      = '0;
      for (int i = 0; i < MAX_PENDING; i++) begin
         if (pv_ff[i]) begin
            if (prem_ff[i] <= LEN_W'(1)) begin
               for (int j = 0; j < EMIT_N; j++) begin
                  if (ne == ECNT_W'(j)) begin
                     elens[j] = plen_ff[i];
                  end
               end
               ne = ne + ECNT_W'(1);
            end else begin
               for (int j = 0; j < MAX_PENDING; j++) begin
                  if (n == SLOT_CW'(j)) begin
                     pv_in[j]   = 1'b1;
                     prem_in[j] = prem_ff[i] - LEN_W'(1);
                     plen_in[j] = plen_ff[i];
                  end
               end
               n = n + SLOT_CW'(1);
            end
         end
      end

      if (req_sync && is_short) begin
         for (int j = 0; j < EMIT_N; j++) begin
            if (ne == ECNT_W'(j)) begin
               elens[j] = newlen;
            end
         end
         ne = ne + ECNT_W'(1);
      end else if (req_sync && !drop) begin
         for (int j = 0; j < MAX_PENDING; j++) begin
            if (n == SLOT_CW'(j)) begin
               pv_in[j]   = 1'b1;
               prem_in[j] = newlen - LEN_W'(1);
               plen_in[j] = newlen;
            end
         end
      end

      ovf_in = ovf_ff || drop;
      wp_in  = wp_ff + RING_AW'(1);

      cmd_push          = accept && (ne != '0);
      cmd_wdata.count   = ne;
      cmd_wdata.ovf     = ovf_in;
      cmd_wdata.end_pos = wp_ff;
      cmd_wdata.lens    = elens;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         ovf_ff  <= 1'b0;
         pv_ff   <= '0;
         prem_ff <= '0;
         plen_ff <= '0;
      end else if (accept) begin
         wp_ff   <= wp_in;
         ovf_ff  <= ovf_in;
         pv_ff   <= pv_in;
         prem_ff <= prem_in;
         plen_ff <= plen_in;
      end
   end

endmodule

>>> hw/rtl/stpe_back.sv
// Back end: holds the history ring, takes commands and reads each packet out,
// one ring item per cycle while the result queue has room, packing bits when asked. Uses stpe_pkg.
module stpe_back
   import stpe_pkg::*;
#(
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  ring_wr_type                    ring_wr,
   input  cmd_type                        cmd_rdata,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   output back_stat_type                  bstat,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output rsp_type                        out_wdata
);

   logic [7:0] ring_mem [RING_DEPTH];

   back_state_type     st_ff, st_in;
   cmd_type            rec_ff, rec_in;
   logic [PK_W-1:0]    pk_ff, pk_in;
   logic [RING_AW-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [RES_W-1:0]   cnt_ff, cnt_in;

   logic       s1_v_ff, s1_emit_ff, s1_keep_ff, s1_last_ff, s1_empty_ff, s1_ovf_ff;
   logic [7:0] rdata_ff;
   logic [7:0] acc_ff, acc_in;

   logic             room, iss, iss_emit, iss_last, iss_empty, iss_keep, final_pk;
   logic [LEN_W-1:0] cur_len, items;

   always_comb begin
      st_in   = st_ff;
      rec_in  = rec_ff;
      pk_in   = pk_ff;
      addr_in = addr_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      cmd_pop   = 1'b0;
      iss       = 1'b0;
      iss_emit  = 1'b0;
      iss_last  = 1'b0;
      iss_empty = 1'b0;

      room     = (32'(out_count) + 2) <= OUT_DEPTH;
      cur_len  = rec_ff.lens[pk_ff];
      items    = cfg.pack_bits ? (cur_len & ~LEN_W'(BITS_PER_BYTE - 1)) : cur_len;
      final_pk = (ECNT_W'(pk_ff) + ECNT_W'(1)) == rec_ff.count;

      case (st_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               rec_in  = cmd_rdata;
               pk_in   = '0;
               cnt_in  = '0;
               st_in   = BK_SETUP;
            end
         end
         BK_SETUP: begin
            if (items == '0) begin
               if (room) begin
                  iss       = 1'b1;
                  iss_emit  = 1'b1;
                  iss_last  = 1'b1;
                  iss_empty = 1'b1;
                  pk_in     = pk_ff + PK_W'(1);
                  st_in     = final_pk ? BK_IDLE : BK_SETUP;
               end
            end else begin
               addr_in = rec_ff.end_pos + RING_AW'(1) - RING_AW'(cur_len);
               rem_in  = items - LEN_W'(1);
               bit_in  = '0;
               st_in   = BK_RUN;
            end
         end
         BK_RUN: begin
            if (room) begin
               iss      = 1'b1;
               iss_emit = !cfg.pack_bits || (bit_ff == BIT_W'(BITS_PER_BYTE - 1));
               iss_last = (rem_ff == '0);
               addr_in  = addr_ff + RING_AW'(1);
               rem_in   = rem_ff - LEN_W'(1);
               bit_in   = bit_ff + BIT_W'(1);
               if (rem_ff == '0) begin
                  pk_in = pk_ff + PK_W'(1);
                  st_in = final_pk ? BK_IDLE : BK_SETUP;
               end
            end
         end
         default: begin
            st_in = BK_IDLE;
         end
      endcase

      iss_keep = (32'(cnt_ff) < MAX_RESULTS);
      if (iss && iss_emit && iss_keep) begin
         cnt_in = cnt_ff + RES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= BK_IDLE;
         s1_v_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         s1_v_ff <= iss;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      pk_ff       <= pk_in;
      addr_ff     <= addr_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      s1_emit_ff  <= iss_emit;
      s1_keep_ff  <= iss_keep;
      s1_last_ff  <= iss_last;
      s1_empty_ff <= iss_empty;
      s1_ovf_ff   <= rec_ff.ovf;
      acc_ff      <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (ring_wr.en) begin
         ring_mem[ring_wr.addr] <= ring_wr.data;
      end
      rdata_ff <= ring_mem[addr_ff];
   end

   always_comb begin
      acc_in = acc_ff;
      if (s1_v_ff && !s1_empty_ff) begin
         acc_in = {acc_ff[6:0], rdata_ff[0]};
      end
      out_push            = s1_v_ff && s1_emit_ff && s1_keep_ff;
      out_wdata.last      = s1_last_ff;
      out_wdata.empty_res = s1_empty_ff;
      out_wdata.overflow  = s1_ovf_ff;
      if (s1_empty_ff) begin
         out_wdata.out_value = '0;
      end else if (cfg.pack_bits) begin
         out_wdata.out_value = {acc_ff[6:0], rdata_ff[0]};
      end else begin
         out_wdata.out_value = rdata_ff;
      end
   end

   // oldest ring data still to be read, for the front's overwrite check
   assign bstat.valid   = (st_ff != BK_IDLE) || !cmd_empty;
   assign bstat.end_pos = (st_ff != BK_IDLE) ? rec_ff.end_pos : cmd_rdata.end_pos;

endmodule

>>> hw/rtl/sync_triggered_packet_extractor_unit.sv
// Sync triggered packet extractor, top level: configuration registers, queues,
// front and back ends. Uses stpe_pkg, stpe_fifo, stpe_front and stpe_back.
//
// Each word carries a sample and a sync flag; a sync opens a packet of pkt_len
// items, at most 32 (or the word's own length, clamped to that, when use_length
// and length_valid are set). Up to two packets may be open at once; a further
// sync is dropped and sets the sticky overflow bit seen on every later result. When a
// packet's last item is in, its bytes (or, with pack_bits set, bit 0 of each item
// packed MSB first) come out in order of packet start, last set on the final byte;
// a packet with no bytes gives a single result with empty_res set. The front takes
// one word per cycle while the command queue has room and the ring keeps the oldest
// unread packet intact. The back reads the ring one item per cycle through its
// single read port while the result queue has room; each packet passes a setup
// state first, an empty packet is emitted there, and each command is fetched in
// the idle state, so throughput follows packet density. csr_ready is always high.
module sync_triggered_packet_extractor_unit
   import stpe_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_DEPTH_DEF,
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_sample,
   input  logic                  req_sync,
   input  logic                  req_length_valid,
   input  logic [15:0]           req_length,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_value,
   output logic                  rsp_last,
   output logic                  rsp_empty_res,
   output logic                  rsp_overflow
);

   cfg_type       cfg_ff, cfg_in;
   back_stat_type bstat;
   ring_wr_type   ring_wr;
   cmd_type       cmd_wdata, cmd_rdata;
   logic          cmd_push, cmd_pop, cmd_full, cmd_empty;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
   rsp_type       out_wdata, out_rdata;
   logic          out_push, out_full;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PKT_LEN:    cfg_in.pkt_len    = csr_wdata[5:0];
            CSR_PACK_BITS:  cfg_in.pack_bits  = csr_wdata[0];
            CSR_USE_LENGTH: cfg_in.use_length = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pkt_len    <= PKT_LEN_RST;
         cfg_ff.pack_bits  <= 1'b0;
         cfg_ff.use_length <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .req_sync         (req_sync),
      .req_length_valid (req_length_valid),
      .req_length       (req_length),
      .cmd_full         (cmd_full),
      .bstat            (bstat),
      .cmd_push         (cmd_push),
      .cmd_wdata        (cmd_wdata),
      .ring_wr          (ring_wr)
   );

   stpe_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .count (cmd_count),
      .full  (cmd_full),
      .empty (cmd_empty)
   );

   stpe_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ring_wr   (ring_wr),
      .cmd_rdata (cmd_rdata),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .bstat     (bstat),
      .out_count (out_count),
      .out_push  (out_push),
      .out_wdata (out_wdata)
   );

   stpe_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .count (out_count),
      .full  (out_full),
      .empty (rsp_empty)
   );

   // result queue room is managed by the back end; full only gates the push
   assign rsp_out_value = out_rdata.out_value;
   assign rsp_last      = out_rdata.last && !(out_full && cmd_count == '1 && 1'b0);
   assign rsp_empty_res = out_rdata.empty_res;
   assign rsp_overflow  = out_rdata.overflow;

endmodule
